// File: src/assert_macros.svh
// Assertion macros shared by the sleep queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define SQTW_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define SQTW_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sqtw_pkg.sv
// Types and codes shared by the sleep queue tick waker.
package sqtw_pkg;

  // Command codes carried on the input tuser
  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes carried on the output tuser
  localparam logic [1:0] ST_PUT_OK = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_WOKEN  = 2'd2;
  localparam logic [1:0] ST_NONE   = 2'd3;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIN,
    S_EMIT_RD,
    S_EMIT_LD
  } sqtw_state_t;

endpackage

// File: src/sqtw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read.
module sqtw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register read data on read enable
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/sleep_queue_tick_waker_unit.sv
// Top level of the sleep queue: slot table, tick walk sequencer and result stage.
// The queue holds up to SLOTS sleeping threads in arrival order. A put beat
// (tuser 0) appends a thread and answers with one result, or status full
// when all slots are taken. A tick beat (tuser 1) walks the slot RAM one
// entry per cycle through one shared decrement and zero compare, followed
// by the closing state S_FIN; survivors are rewritten compacted in place and
// woken ids go to a wake buffer. Woken ids then leave in queue order, each
// result by a buffer read and then a load of the output register, the final
// one with tlast; a tick that wakes nobody answers with one status-3 result
// from the closing state. Every result carries the occupancy after the whole
// step. Output stalls can hold the closing state and each result load;
// s_axis_tready stays low until the last result of the current beat is loaded
// into the output register and that register is free again.
`include "assert_macros.svh"

module sleep_queue_tick_waker_unit
  import sqtw_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 16,
  parameter int ID_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] thread_id, [23:8] duration
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] woken_id, [12:8] occupancy, [15:13] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // last
);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW = ID_BITS + TIME_BITS;

  sqtw_state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] rd;
  logic [CW-1:0] kept;
  logic [CW-1:0] nwake;
  logic [CW-1:0] e;
  logic          pend;

  logic [7:0]    out_id;
  logic [4:0]    out_occ;
  logic [1:0]    out_status;
  logic          out_last;

  // Input field extraction
  logic [ID_BITS+7:0]    id_wide;
  logic [TIME_BITS+15:0] dur_wide;
  logic [ID_BITS-1:0]    in_id;
  logic [TIME_BITS-1:0]  in_dur;
  assign id_wide  = {{ID_BITS{1'b0}}, s_axis_tdata[7:0]};
  assign dur_wide = {{TIME_BITS{1'b0}}, s_axis_tdata[23:8]};
  assign in_id    = id_wide[ID_BITS-1:0];
  assign in_dur   = dur_wide[TIME_BITS-1:0];

  logic out_free, accept, is_full, issue, walk_done;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign is_full   = (count == CW'(SLOTS));
  assign issue     = (rd < count);
  assign walk_done = !issue && !pend;

  // Slot and wake buffer RAM ports
  logic               slot_we, slot_re, wake_we, wake_re;
  logic [AW-1:0]      slot_waddr, slot_raddr, wake_waddr, wake_raddr;
  logic [EW-1:0]      slot_wdata, slot_rdata;
  logic [ID_BITS-1:0] wake_wdata, wake_rdata;

  sqtw_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  sqtw_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (wake_waddr),
    .wdata (wake_wdata),
    .re    (wake_re),
    .raddr (wake_raddr),
    .rdata (wake_rdata)
  );

  // Shared decrement and zero compare on the entry just read
  logic [ID_BITS-1:0]   rd_id;
  logic [TIME_BITS-1:0] rd_ticks, dec_ticks;
  logic                 expired;
  assign rd_id     = slot_rdata[EW-1:TIME_BITS];
  assign rd_ticks  = slot_rdata[TIME_BITS-1:0];
  assign dec_ticks = rd_ticks - TIME_BITS'(1);
  assign expired   = (dec_ticks == '0);

  // Occupancy and id narrowing to the fixed output widths
  logic [CW-1:0]      cnt_inc, e_inc;
  logic [CW+4:0]      occ_put_w, occ_cur_w;
  logic [ID_BITS+7:0] wid_wide;
  logic               emit_last;
  assign cnt_inc   = count + CW'(1);
  assign e_inc     = e + CW'(1);
  assign occ_put_w = {5'b0, cnt_inc};
  assign occ_cur_w = {5'b0, count};
  assign wid_wide  = {8'b0, wake_rdata};
  assign emit_last = (e_inc == nwake);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && s_axis_tuser == CMD_TICK) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (nwake != '0) begin
          state_next = S_EMIT_RD;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          state_next = emit_last ? S_IDLE : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // RAM controls and result loading
  logic       load_out;
  logic [1:0] status_next;
  logic [7:0] id_next;
  logic [4:0] occ_next;
  logic       last_next;

  always_comb begin
    slot_we     = 1'b0;
    slot_waddr  = rd[AW-1:0];
    slot_wdata  = {in_id, in_dur};
    slot_re     = 1'b0;
    slot_raddr  = rd[AW-1:0];
    wake_we     = 1'b0;
    wake_waddr  = nwake[AW-1:0];
    wake_wdata  = rd_id;
    wake_re     = 1'b0;
    wake_raddr  = e[AW-1:0];
    load_out    = 1'b0;
    status_next = ST_PUT_OK;
    id_next     = 8'd0;
    occ_next    = occ_cur_w[4:0];
    last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept && s_axis_tuser == CMD_PUT) begin
          load_out = 1'b1;
          if (is_full) begin
            status_next = ST_FULL;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = count[AW-1:0];
            occ_next   = occ_put_w[4:0];
          end
        end
      end
      S_WALK: begin
        slot_re = issue;
        if (pend) begin
          if (expired) begin
            wake_we = 1'b1;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = kept[AW-1:0];
            slot_wdata = {rd_id, dec_ticks};
          end
        end
      end
      S_FIN: begin
        if (nwake == '0 && out_free) begin
          load_out    = 1'b1;
          status_next = ST_NONE;
        end
      end
      S_EMIT_RD: begin
        wake_re = 1'b1;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          load_out    = 1'b1;
          status_next = ST_WOKEN;
          id_next     = wid_wide[7:0];
          last_next   = emit_last;
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      pend          <= 1'b0;
    end else begin
      state <= state_next;
      // Hold the result until taken, then load the next one
      if (load_out) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept && s_axis_tuser == CMD_PUT && !is_full) begin
        count <= cnt_inc;
      end
      if (state == S_WALK && walk_done) begin
        count <= kept;
      end
      if (state == S_WALK) begin
        pend <= issue;
      end else begin
        pend <= 1'b0;
      end
    end
  end

  // Walk and emit counters, result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rd    <= '0;
      kept  <= '0;
      nwake <= '0;
      e     <= '0;
    end
    if (state == S_WALK) begin
      if (issue) begin
        rd <= rd + CW'(1);
      end
      if (pend) begin
        if (expired) begin
          nwake <= nwake + CW'(1);
        end else begin
          kept <= kept + CW'(1);
        end
      end
    end
    if (state == S_EMIT_LD && out_free) begin
      e <= e_inc;
    end
    if (load_out) begin
      out_status <= status_next;
      out_id     <= id_next;
      out_occ    <= occ_next;
      out_last   <= last_next;
    end
  end

  assign m_axis_tdata = {3'b0, out_occ, out_id};
  assign m_axis_tuser = out_status;
  assign m_axis_tlast = out_last;

  // Walk bookkeeping: every entry read is either kept, woken or in flight
  logic [CW:0] walk_seen;
  logic        walk_even, tick_beat, emit_load, woken_out;
  assign walk_seen = (CW+1)'(kept) + (CW+1)'(nwake) + (CW+1)'(pend);
  assign walk_even = (walk_seen == (CW+1)'(rd));
  assign tick_beat = accept && (s_axis_tuser == CMD_TICK);
  assign emit_load = (state == S_EMIT_LD) && out_free;
  assign woken_out = m_axis_tvalid && (m_axis_tuser == ST_WOKEN);

  `SQTW_CHECK(a_count_bound, count <= CW'(SLOTS), "occupancy beyond slot count")
  `SQTW_CHECK(a_walk_balance, (state != S_WALK) || walk_even, "walk lost an entry")
  `SQTW_CHECK_NEXT(a_tick_walks, tick_beat, state == S_WALK, "tick did not start a walk")
  `SQTW_CHECK_NEXT(a_emit_order, emit_load, woken_out, "woken result not loaded")

endmodule

// File: tb/sv/tb_sleep_queue_tick_waker_unit.sv
// Self-checking testbench for the sleep queue tick waker: random put/tick traffic, scoreboard.
module tb_sleep_queue_tick_waker_unit
  import sqtw_pkg::*;
();

  localparam int SLOTS       = 16;
  localparam int IDLE_LIMIT  = 3000;  // cycles without any beat before giving up
  localparam int HOLD_CYCLES = 400;   // long output stall to back up the queue
  localparam int CALM_TAIL   = 60;    // final beats sent with no idling
  localparam int DRAIN_WAIT  = 80;    // wait for stray results after the last due one

  typedef struct packed {
    logic        cmd;
    logic [7:0]  id;
    logic [15:0] ticks;
  } sleep_cmd_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] woken_id;
    logic       is_last;
    logic [4:0] occupancy;
  } wake_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Commands still to send, and results the sleep table is due to produce
  sleep_cmd_t   cmd_backlog[$];
  wake_result_t results_due[$];

  // Shadow copy of the sleep table
  logic [7:0]  sleeper_id[SLOTS];
  logic [15:0] sleeper_ticks[SLOTS];
  int unsigned sleeper_cnt = 0;

  int unsigned total_beats = 0;
  int unsigned beats_in = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned idle_cycles = 0;

  sleep_queue_tick_waker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one accepted command to the shadow table and queue its results
  task automatic sleep_table_step(input sleep_cmd_t c);
    wake_result_t r;
    logic [7:0]   woke[SLOTS];
    int unsigned  n_woke;
    int unsigned  kept;
    logic [15:0]  t;
    n_woke = 0;
    kept = 0;
    r = '0;
    if (c.cmd == CMD_PUT) begin
      if (sleeper_cnt >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        sleeper_id[sleeper_cnt] = c.id;
        sleeper_ticks[sleeper_cnt] = c.ticks;
        sleeper_cnt++;
        r.status = ST_PUT_OK;
      end
      r.is_last = 1'b1;
      r.occupancy = 5'(sleeper_cnt);
      results_due.push_back(r);
    end else begin
      // Decrement every sleeper, compact the survivors, collect the woken
      for (int i = 0; i < sleeper_cnt; i++) begin
        t = sleeper_ticks[i] - 16'd1;
        if (t == 16'd0) begin
          woke[n_woke] = sleeper_id[i];
          n_woke++;
        end else begin
          sleeper_id[kept] = sleeper_id[i];
          sleeper_ticks[kept] = t;
          kept++;
        end
      end
      sleeper_cnt = kept;
      r.occupancy = 5'(sleeper_cnt);
      if (n_woke == 0) begin
        r.status = ST_NONE;
        r.is_last = 1'b1;
        results_due.push_back(r);
      end else begin
        for (int i = 0; i < n_woke; i++) begin
          r.status = ST_WOKEN;
          r.woken_id = woke[i];
          r.is_last = (i == n_woke - 1);
          results_due.push_back(r);
        end
      end
    end
  endtask

  task automatic queue_cmd(input logic cmd, input logic [7:0] id, input logic [15:0] ticks);
    sleep_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.ticks = ticks;
    cmd_backlog.push_back(c);
  endtask

  task automatic note_mismatch(input string what, input wake_result_t want,
                               input wake_result_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("mismatch (%s): expected st=%0d id=%02h last=%0b occ=%0d",
               what, want.status, want.woken_id, want.is_last, want.occupancy);
      $display("  actual st=%0d id=%02h last=%0b occ=%0d",
               got.status, got.woken_id, got.is_last, got.occupancy);
    end
  endtask

  // Driver: feed the backlog, hold a beat until taken, idle in bursts
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        sleep_table_step(cmd_backlog.pop_front());
        beats_in <= beats_in + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cmd_backlog.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (beats_in + CALM_TAIL < total_beats && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cmd_backlog[0].ticks, cmd_backlog[0].id};
        s_axis_tuser <= cmd_backlog[0].cmd;
      end
    end
  end

  // Monitor: check each result beat, stall the output side in bursts
  always @(posedge clk) begin
    wake_result_t got;
    wake_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.woken_id = m_axis_tdata[7:0];
        got.is_last = m_axis_tlast;
        got.occupancy = m_axis_tdata[12:8];
        if (results_due.size() == 0) begin
          note_mismatch("no result due", '0, got);
        end else begin
          want = results_due.pop_front();
          if (got.status != want.status)
            note_mismatch("status", want, got);
          else if (got.woken_id != want.woken_id)
            note_mismatch("woken id", want, got);
          else if (got.is_last != want.is_last)
            note_mismatch("last", want, got);
          else if (got.occupancy != want.occupancy)
            note_mismatch("occupancy", want, got);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && beats_in >= 120) begin
        // Hold off long enough for the queue to stall its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (beats_in + CALM_TAIL < total_beats && $urandom_range(0, 11) == 0) begin
        recv_gap = $urandom_range(1, 18) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: stop when no beat moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned kind;
    int unsigned n;
    // Tick on an empty table
    queue_cmd(CMD_TICK, 8'h00, 16'h0000);
    // Zero duration wraps to the full range; all-ones id and duration
    queue_cmd(CMD_PUT, 8'h00, 16'h0000);
    queue_cmd(CMD_PUT, 8'hFF, 16'hFFFF);
    // Tick where nobody reaches zero
    queue_cmd(CMD_TICK, 8'hFF, 16'hFFFF);
    // Fill the table with short sleepers, then one put too many
    for (int i = 0; i < SLOTS - 2; i++)
      queue_cmd(CMD_PUT, {4'(i), ~4'(i)}, 16'(i % 3 + 1));
    queue_cmd(CMD_PUT, 8'h5A, 16'h0001);
    // Ticks that wake several threads at once
    repeat (3) queue_cmd(CMD_TICK, 8'($urandom), 16'($urandom));

    // Random traffic, mostly put groups followed by ticks
    while (cmd_backlog.size() < 450) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n = $urandom_range(1, 5);
        repeat (n) queue_cmd(CMD_PUT, 8'($urandom), 16'($urandom_range(1, 6)));
        n = $urandom_range(1, 4);
        repeat (n) queue_cmd(CMD_TICK, 8'($urandom), 16'($urandom));
      end else if (kind < 90) begin
        n = $urandom_range(1, 8);
        repeat (n) queue_cmd(CMD_TICK, 8'($urandom), 16'($urandom));
      end else if (kind < 97) begin
        n = $urandom_range(8, 20);
        repeat (n) queue_cmd(CMD_PUT, 8'($urandom), 16'($urandom_range(1, 40)));
      end else begin
        queue_cmd(CMD_PUT, 8'($urandom), 16'($urandom));
      end
    end
    total_beats = cmd_backlog.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Wait for all commands, then for every due result, then for stragglers
    while (beats_in < total_beats) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0 && results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/sqtw_pkg.sv
src/sqtw_ram.sv
src/sleep_queue_tick_waker_unit.sv
tb/sv/tb_sleep_queue_tick_waker_unit.sv
